// ===== design/csv_pkg.sv =====
// Package for the CBOR stream validator: payload types, status codes, limits.
package csv_pkg;

  localparam int StackDepthDef = 16;

  localparam logic [3:0] ST_PENDING  = 4'd0;
  localparam logic [3:0] ST_VALID    = 4'd1;
  localparam logic [3:0] ST_TRUNC    = 4'd2;
  localparam logic [3:0] ST_UNSUP    = 4'd3;
  localparam logic [3:0] ST_INVALID  = 4'd4;
  localparam logic [3:0] ST_NONCANON = 4'd5;
  localparam logic [3:0] ST_CAPACITY = 4'd6;
  localparam logic [3:0] ST_DEPTH    = 4'd7;
  localparam logic [3:0] ST_RANGE    = 4'd8;
  localparam logic [3:0] ST_UTF8     = 4'd9;
  localparam logic [3:0] ST_TRAILING = 4'd10;

  localparam logic [1:0] REG_MAX_NESTING = 2'd0;
  localparam logic [1:0] REG_MAX_BSTR    = 2'd1;
  localparam logic [1:0] REG_MAX_TEXT    = 2'd2;
  localparam logic [1:0] REG_MAX_ITEMS   = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [3:0] status;
    logic       final_res;
  } out_item_t;

endpackage

// ===== design/cbor_stream_validator_top.sv =====
// Top level of the streaming CBOR well-formedness validator.
//
// Usage: bytes of a CBOR message arrive on the in_ channel (valid/stall),
// one transaction per byte; last ends the message, has_byte 0 allows an
// end marker without a byte. Every input transaction yields exactly one
// out_ transaction: status holds the first error seen so far (0 if none)
// with final_res 0, or on last the verdict for the whole message with
// final_res 1, after which parse state clears for the next message.
// out_valid rises in the cycle after acceptance; throughput is one byte per
// cycle while out_stall is low, set by the single register stage holding
// the result. in_stall is raised only while a result is held and out_stall
// is high, so a stalled receiver holds the result and blocks the input
// until it releases. The user must write the limit registers on the cfg_
// port only while idle; the block does not enforce it. Reset (rst_n low,
// synchronous) restores limits 8, 65535, 65535, 255, clears the container
// stack and drops out_valid. No clearing pass.
module cbor_stream_validator_top
  import csv_pkg::*;
#(
  parameter int STACK_DEPTH = StackDepthDef
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int LW = $clog2(STACK_DEPTH + 1);
  localparam int IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  typedef enum logic [1:0] {PH_HEAD, PH_ARG, PH_STR, PH_DONE} phase_t;

  logic [4:0]  max_nesting_r;
  logic [31:0] max_bstr_r, max_text_r, max_items_r;

  logic [32:0] rem_r   [STACK_DEPTH];
  logic [32:0] rem_nxt [STACK_DEPTH];
  logic [LW-1:0] lvl_r, lvl_nxt;
  phase_t      phase_r, phase_nxt;
  logic [7:0]  head_r, head_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [3:0]  argl_r, argl_nxt;
  logic [31:0] strl_r, strl_nxt;
  logic [7:0]  utf_r, utf_nxt;
  logic [3:0]  sticky_r, sticky_nxt;
  logic        out_valid_r;
  out_item_t   out_r, out_nxt;

  logic accept;
  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // pop detection: lowest level k such that every level from k+1..lvl closes
  logic [STACK_DEPTH+1:0] ends_at;   // ends_at[j]: levels j..lvl all hold one
  always_comb begin
    ends_at[0] = 1'b1;
    ends_at[STACK_DEPTH+1] = 1'b1;
    for (int j = STACK_DEPTH; j >= 1; j--) begin
      if (j > int'(lvl_r)) ends_at[j] = 1'b1;
      else ends_at[j] = (rem_r[j-1] == 33'd1) && ends_at[j+1];
    end
  end

  // item_done helper outcome
  logic [LW-1:0] done_lvl;   // level whose counter decrements, 0 => value done
  always_comb begin
    done_lvl = '0;
    for (int j = 1; j <= STACK_DEPTH; j++) begin
      if (j <= int'(lvl_r) && !(ends_at[j])) done_lvl = LW'(j);
    end
  end

  logic [2:0]  maj;
  logic [4:0]  add;
  logic [63:0] arg;
  logic        do_head, do_item;
  logic [7:0]  ub;
  logic [1:0]  owed;
  logic [2:0]  cls;
  logic [7:0]  lo, hi;
  logic [LW:0] newlvl;
  logic [33:0] cnt;

  always_comb begin
    lvl_nxt = lvl_r; phase_nxt = phase_r; head_nxt = head_r; acc_nxt = acc_r;
    argl_nxt = argl_r; strl_nxt = strl_r; utf_nxt = utf_r; sticky_nxt = sticky_r;
    for (int j = 0; j < STACK_DEPTH; j++) rem_nxt[j] = rem_r[j];
    do_head = 1'b0; do_item = 1'b0;
    maj = head_r[7:5]; add = head_r[4:0]; arg = acc_r;
    ub = in_data.data_byte; owed = utf_r[1:0]; cls = utf_r[4:2];
    lo = 8'h80; hi = 8'hBF; newlvl = '0; cnt = '0;

    if (in_data.has_byte && sticky_r == ST_PENDING) begin
      unique case (phase_r)
        PH_DONE: sticky_nxt = ST_TRAILING;
        PH_ARG: begin
          acc_nxt = {acc_r[55:0], ub};
          arg = acc_nxt;
          if (argl_r != 4'd0) argl_nxt = argl_r - 4'd1;
          if (argl_nxt == 4'd0) do_head = 1'b1;
        end
        PH_STR: begin
          if (maj == 3'd3 && !utf_r[7]) begin
            if (owed == 2'd0) begin
              priority if (ub < 8'h80) utf_nxt = utf_r;
              else if (ub < 8'hC2) utf_nxt = 8'h80;
              else if (ub < 8'hE0) utf_nxt = 8'd1;
              else if (ub < 8'hF0)
                utf_nxt = {3'b0, (ub == 8'hE0) ? 3'd1 : ((ub == 8'hED) ? 3'd2 : 3'd0), 2'd2};
              else if (ub < 8'hF5)
                utf_nxt = {3'b0, (ub == 8'hF0) ? 3'd3 : ((ub == 8'hF4) ? 3'd4 : 3'd0), 2'd3};
              else utf_nxt = 8'h80;
            end else begin
              if (cls == 3'd1) lo = 8'hA0;
              else if (cls == 3'd2) hi = 8'h9F;
              else if (cls == 3'd3) lo = 8'h90;
              else if (cls == 3'd4) hi = 8'h8F;
              if (ub < lo || ub > hi) utf_nxt = 8'h80;
              else utf_nxt = {6'b0, owed - 2'd1};
            end
          end
          if (strl_r != 32'd0) strl_nxt = strl_r - 32'd1;
          if (strl_nxt == 32'd0) begin
            if (maj == 3'd3 && (utf_nxt & 8'h83) != 8'd0) sticky_nxt = ST_UTF8;
            else do_item = 1'b1;
          end
        end
        default: begin
          head_nxt = ub; maj = ub[7:5]; add = ub[4:0];
          acc_nxt = '0;
          if (add < 5'd24) begin
            acc_nxt = {59'd0, add}; arg = acc_nxt; do_head = 1'b1;
          end else if (add == 5'd31) sticky_nxt = ST_UNSUP;
          else if (add > 5'd27) sticky_nxt = ST_INVALID;
          else begin
            argl_nxt = 4'd1 << (add - 5'd24);
            phase_nxt = PH_ARG;
          end
        end
      endcase

      if (do_head) begin
        newlvl = {1'b0, lvl_r} + 1'b1;
        cnt = (maj == 3'd5) ? {arg[32:0], 1'b0} : {1'b0, arg[32:0]};
        if (maj != 3'd7 && ((add == 5'd24 && arg < 64'd24) ||
            (add == 5'd25 && arg <= 64'hFF) || (add == 5'd26 && arg <= 64'hFFFF) ||
            (add == 5'd27 && arg <= 64'hFFFF_FFFF)))
          sticky_nxt = ST_NONCANON;
        else if (maj == 3'd6 || (maj == 3'd7 && add != 5'd20 && add != 5'd21 &&
                 add != 5'd22 && add != 5'd26 && add != 5'd27))
          sticky_nxt = ST_UNSUP;
        else if (maj == 3'd2 || maj == 3'd3) begin
          if (arg > {32'd0, (maj == 3'd2) ? max_bstr_r : max_text_r})
            sticky_nxt = ST_CAPACITY;
          else if (arg == 64'd0) do_item = 1'b1;
          else begin
            strl_nxt = arg[31:0]; utf_nxt = '0; phase_nxt = PH_STR;
          end
        end else if (maj == 3'd4 || maj == 3'd5) begin
          if (newlvl > (LW+1)'(max_nesting_r) || newlvl > (LW+1)'(STACK_DEPTH))
            sticky_nxt = ST_DEPTH;
          else if (arg > {32'd0, max_items_r}) sticky_nxt = ST_CAPACITY;
          else if (cnt == 34'd0) do_item = 1'b1;
          else begin
            rem_nxt[lvl_r[IW-1:0]] = cnt[32:0];
            lvl_nxt = newlvl[LW-1:0];
            phase_nxt = PH_HEAD;
          end
        end else if (maj == 3'd7 && add == 5'd26 && arg[30:23] == 8'hFF)
          sticky_nxt = ST_RANGE;
        else if (maj == 3'd7 && add == 5'd27 && arg[62:52] == 11'h7FF)
          sticky_nxt = ST_RANGE;
        else do_item = 1'b1;
      end

      if (do_item) begin
        if (done_lvl == '0) begin
          lvl_nxt = '0; phase_nxt = PH_DONE;
        end else begin
          rem_nxt[done_lvl[IW-1:0] - IW'(1)] = rem_r[done_lvl[IW-1:0] - IW'(1)] - 33'd1;
          lvl_nxt = done_lvl; phase_nxt = PH_HEAD;
        end
      end
    end

    out_nxt.status = sticky_nxt;
    out_nxt.final_res = in_data.last;
    if (in_data.last) begin
      if (sticky_nxt == ST_PENDING)
        out_nxt.status = (phase_nxt == PH_DONE) ? ST_VALID : ST_TRUNC;
      for (int j = 0; j < STACK_DEPTH; j++) rem_nxt[j] = '0;
      lvl_nxt = '0; phase_nxt = PH_HEAD; head_nxt = '0; acc_nxt = '0;
      argl_nxt = '0; strl_nxt = '0; utf_nxt = '0; sticky_nxt = ST_PENDING;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_nesting_r <= 5'd8; max_bstr_r <= 32'd65535;
      max_text_r <= 32'd65535; max_items_r <= 32'd255;
      for (int j = 0; j < STACK_DEPTH; j++) rem_r[j] <= '0;
      lvl_r <= '0; phase_r <= PH_HEAD; head_r <= '0; acc_r <= '0;
      argl_r <= '0; strl_r <= '0; utf_r <= '0; sticky_r <= ST_PENDING;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MAX_NESTING: max_nesting_r <= cfg_data[4:0];
          REG_MAX_BSTR:    max_bstr_r <= cfg_data;
          REG_MAX_TEXT:    max_text_r <= cfg_data;
          REG_MAX_ITEMS:   max_items_r <= cfg_data;
        endcase
      end
      if (accept) begin
        for (int j = 0; j < STACK_DEPTH; j++) rem_r[j] <= rem_nxt[j];
        lvl_r <= lvl_nxt; phase_r <= phase_nxt; head_r <= head_nxt; acc_r <= acc_nxt;
        argl_r <= argl_nxt; strl_r <= strl_nxt; utf_r <= utf_nxt; sticky_r <= sticky_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) out_r <= out_nxt;
  end

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(lvl_r) <= STACK_DEPTH) else $error("stack level past depth");
  a_done_empty: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DONE |-> lvl_r == '0) else $error("done with open containers");
  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.last |=> sticky_r == ST_PENDING && lvl_r == '0)
    else $error("message end did not clear state");
  a_final_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.final_res |-> out_data.status != ST_PENDING)
    else $error("final result pending");

endmodule

// ===== bench/cbor_stream_validator_top_tb.sv =====
// Testbench for the CBOR stream validator: byte-level predictor with directed and random messages.
`timescale 1ns / 100ps

module cbor_stream_validator_top_tb;
  import csv_pkg::*;

  localparam int STACK_N = StackDepthDef;
  localparam int IDLE_LIMIT = 20000;

  localparam logic [1:0] PH_HEAD = 2'd0;
  localparam logic [1:0] PH_ARG  = 2'd1;
  localparam logic [1:0] PH_STR  = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  cbor_stream_validator_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [4:0]  lim_nest;
  logic [31:0] lim_bstr, lim_text, lim_items;
  logic [64:0] kids_left [STACK_N];
  int unsigned open_lvl;
  logic [1:0]  phase;
  logic [7:0]  head_byte;
  logic [63:0] arg_acc;
  int unsigned arg_left;
  logic [31:0] str_left;
  logic [7:0]  utf_st;
  logic [3:0]  held_err;

  out_item_t status_q[$];
  int errors = 0;
  int n_results = 0;
  int n_msgs = 0;
  int n_sent = 0;
  logic stim_done = 1'b0;
  logic long_hold = 1'b0;
  int idle_cycles = 0;

  task automatic report(input string what, input out_item_t got, input out_item_t want);
    $display("mismatch %s: got status %0d final %0d, want status %0d final %0d at %0t",
             what, got.status, got.final_res, want.status, want.final_res, $realtime);
    errors++;
  endtask

  function automatic void flag(input logic [3:0] code);
    if (held_err == ST_PENDING) held_err = code;
  endfunction

  function automatic void clear_msg();
    for (int i = 0; i < STACK_N; i++) kids_left[i] = '0;
    open_lvl = 0; phase = PH_HEAD; head_byte = '0; arg_acc = '0;
    arg_left = 0; str_left = '0; utf_st = '0; held_err = ST_PENDING;
  endfunction

  function automatic void value_closed();
    while (open_lvl > 0) begin
      if (kids_left[open_lvl-1] != 0) kids_left[open_lvl-1]--;
      if (kids_left[open_lvl-1] != 0) begin
        phase = PH_HEAD;
        return;
      end
      open_lvl--;
    end
    phase = PH_DONE;
  endfunction

  function automatic void utf_byte(input logic [7:0] b);
    logic [1:0] owed;
    logic [2:0] cls;
    logic [7:0] lo, hi;
    owed = utf_st[1:0];
    cls = utf_st[4:2];
    lo = 8'h80;
    hi = 8'hBF;
    if (utf_st[7]) return;
    if (owed == 0) begin
      if (b < 8'h80) return;
      if (b < 8'hC2) utf_st = 8'h80;
      else if (b < 8'hE0) utf_st = 8'd1;
      else if (b < 8'hF0) utf_st = {3'b0, (b == 8'hE0) ? 3'd1 : (b == 8'hED) ? 3'd2 : 3'd0, 2'd2};
      else if (b < 8'hF5) utf_st = {3'b0, (b == 8'hF0) ? 3'd3 : (b == 8'hF4) ? 3'd4 : 3'd0, 2'd3};
      else utf_st = 8'h80;
      return;
    end
    case (cls)
      3'd1: lo = 8'hA0;
      3'd2: hi = 8'h9F;
      3'd3: lo = 8'h90;
      3'd4: hi = 8'h8F;
      default: ;
    endcase
    if (b < lo || b > hi) utf_st = 8'h80;
    else utf_st = {6'b0, owed - 2'd1};
  endfunction

  function automatic void head_done();
    logic [2:0] major;
    logic [4:0] addl;
    logic [64:0] cnt;
    int unsigned lvl;
    major = head_byte[7:5];
    addl = head_byte[4:0];
    if (major != 3'd7 && ((addl == 24 && arg_acc < 24) || (addl == 25 && arg_acc <= 64'hFF) ||
        (addl == 26 && arg_acc <= 64'hFFFF) || (addl == 27 && arg_acc <= 64'hFFFF_FFFF))) begin
      flag(ST_NONCANON);
      return;
    end
    if (major == 3'd6 || (major == 3'd7 && !(addl inside {5'd20, 5'd21, 5'd22, 5'd26, 5'd27}))) begin
      flag(ST_UNSUP);
      return;
    end
    if (major == 3'd2 || major == 3'd3) begin
      if (arg_acc > {32'b0, (major == 3'd2) ? lim_bstr : lim_text}) begin
        flag(ST_CAPACITY);
        return;
      end
      if (arg_acc == 0) begin
        value_closed();
        return;
      end
      str_left = arg_acc[31:0];
      utf_st = '0;
      phase = PH_STR;
      return;
    end
    if (major == 3'd4 || major == 3'd5) begin
      lvl = open_lvl + 1;
      if (lvl > lim_nest || lvl > STACK_N) begin
        flag(ST_DEPTH);
        return;
      end
      if (arg_acc > {32'b0, lim_items}) begin
        flag(ST_CAPACITY);
        return;
      end
      cnt = (major == 3'd5) ? {arg_acc, 1'b0} : {1'b0, arg_acc};
      if (cnt == 0) begin
        value_closed();
        return;
      end
      kids_left[lvl-1] = cnt;
      open_lvl = lvl;
      phase = PH_HEAD;
      return;
    end
    if (major == 3'd7 && addl == 26 && arg_acc[30:23] == 8'hFF) begin
      flag(ST_RANGE);
      return;
    end
    if (major == 3'd7 && addl == 27 && arg_acc[62:52] == 11'h7FF) begin
      flag(ST_RANGE);
      return;
    end
    value_closed();
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    if (phase == PH_DONE) flag(ST_TRAILING);
    else if (phase == PH_ARG) begin
      arg_acc = {arg_acc[55:0], b};
      if (arg_left > 0) arg_left--;
      if (arg_left == 0) head_done();
    end else if (phase == PH_STR) begin
      if (head_byte[7:5] == 3'd3) utf_byte(b);
      if (str_left > 0) str_left--;
      if (str_left == 0) begin
        if (head_byte[7:5] == 3'd3 && (utf_st & 8'h83) != 0) flag(ST_UTF8);
        else value_closed();
      end
    end else begin
      head_byte = b;
      arg_acc = '0;
      if (b[4:0] < 24) begin
        arg_acc = 64'(b[4:0]);
        head_done();
      end else if (b[4:0] == 31) flag(ST_UNSUP);
      else if (b[4:0] > 27) flag(ST_INVALID);
      else begin
        arg_left = 1 << (b[4:0] - 24);
        phase = PH_ARG;
      end
    end
  endfunction

  function automatic out_item_t predict_status(input in_item_t it);
    out_item_t r;
    if (it.has_byte && held_err == ST_PENDING) parse_byte(it.data_byte);
    r.status = held_err;
    r.final_res = 1'b0;
    if (it.last) begin
      r.status = (held_err != ST_PENDING) ? held_err : (phase == PH_DONE) ? ST_VALID : ST_TRUNC;
      r.final_res = 1'b1;
      clear_msg();
    end
    return r;
  endfunction

  // send one byte transaction and record its expected status;
  // in_valid stays up after acceptance until the next call or drain() moves it
  task automatic push_byte(input logic [7:0] b, input logic has, input logic lst,
                           input int gap_max);
    in_item_t it;
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.data_byte = b;
    it.has_byte = has;
    it.last = lst;
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    status_q.push_back(predict_status(it));
    n_sent++;
    if (lst) n_msgs++;
  endtask

  task automatic push_msg(input logic [7:0] bytes[$], input int gap_max);
    for (int i = 0; i < bytes.size(); i++)
      push_byte(bytes[i], 1'b1, i == bytes.size() - 1, gap_max);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_MAX_NESTING: lim_nest = val[4:0];
      REG_MAX_BSTR:    lim_bstr = val;
      REG_MAX_TEXT:    lim_text = val;
      default:         lim_items = val;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // random well-formed value, sometimes corrupted
  function automatic void gen_value(ref logic [7:0] q[$], input int depth);
    int kind, n;
    logic [31:0] v;
    kind = $urandom_range(0, 9);
    if (depth > 3 && kind >= 7) kind = 0;
    case (kind)
      0, 1: begin
        v = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 300);
        if (v < 24) q.push_back({kind[0] ? 3'd1 : 3'd0, v[4:0]});
        else if (v < 256) begin q.push_back({kind[0] ? 3'd1 : 3'd0, 5'd24}); q.push_back(v[7:0]); end
        else if (v < 65536) begin
          q.push_back({kind[0] ? 3'd1 : 3'd0, 5'd25}); q.push_back(v[15:8]); q.push_back(v[7:0]);
        end else begin
          q.push_back({kind[0] ? 3'd1 : 3'd0, 5'd26});
          for (int i = 3; i >= 0; i--) q.push_back(v[i*8 +: 8]);
        end
      end
      2: q.push_back({3'd7, 5'd20 + 5'($urandom_range(0, 2))});
      3: begin
        q.push_back({3'd7, 5'd26});
        v = $urandom;
        if ($urandom_range(0, 5) == 0) v[30:23] = 8'hFF;
        for (int i = 3; i >= 0; i--) q.push_back(v[i*8 +: 8]);
      end
      4: begin
        q.push_back({3'd7, 5'd27});
        v = $urandom;
        if ($urandom_range(0, 5) == 0) v[30:20] = 11'h7FF;
        for (int i = 3; i >= 0; i--) q.push_back(v[i*8 +: 8]);
        v = $urandom;
        for (int i = 3; i >= 0; i--) q.push_back(v[i*8 +: 8]);
      end
      5, 6: begin
        n = $urandom_range(0, 30);
        if (n < 24) q.push_back({(kind == 5) ? 3'd2 : 3'd3, 5'(n)});
        else begin q.push_back({(kind == 5) ? 3'd2 : 3'd3, 5'd24}); q.push_back(8'(n)); end
        for (int i = 0; i < n; i++) begin
          if (kind == 5 || $urandom_range(0, 9) == 0) q.push_back(8'($urandom));
          else if ($urandom_range(0, 3) == 0) begin
            q.push_back(8'hC3); q.push_back(8'hA9);   // two-byte sequence, may be cut
          end else q.push_back(8'($urandom_range(32, 126)));
        end
      end
      default: begin
        n = $urandom_range(0, 3);
        q.push_back({(kind == 7) ? 3'd4 : 3'd5, 5'(n)});
        for (int i = 0; i < ((kind == 7) ? n : 2 * n); i++) gen_value(q, depth + 1);
      end
    endcase
  endfunction

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (status_q.size() == 0) begin
        report("unexpected result", out_data, '0);
      end else begin
        if (out_data !== status_q[0]) report("status", out_data, status_q[0]);
        void'(status_q.pop_front());
        n_results++;
      end
    end
  end

  // receiver stall: random gaps per transaction, with a long hold-off once
  initial begin
    int w;
    @(posedge rst_n);
    forever begin
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (60) @(posedge clk);
        long_hold = 1'b0;
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      if (stim_done) w = 0;
      if (w != 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout");
      $display("RESULT: ERROR");
      $finish;
    end
  end

  typedef struct {
    logic [7:0] b;
    logic has;
    logic lst;
    logic chk;
    logic [3:0] want;
  } dir_row_t;

  dir_row_t dir_tab[] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, ST_TRUNC},     // empty message
    '{8'h00, 1'b1, 1'b1, 1'b1, ST_VALID},     // unsigned zero
    '{8'h17, 1'b1, 1'b1, 1'b1, ST_VALID},
    '{8'h1F, 1'b1, 1'b1, 1'b1, ST_UNSUP},     // indefinite length
    '{8'h1C, 1'b1, 1'b1, 1'b1, ST_INVALID},   // reserved additional info
    '{8'h18, 1'b1, 1'b0, 1'b0, ST_PENDING},
    '{8'h05, 1'b1, 1'b1, 1'b1, ST_NONCANON},  // short form was possible
    '{8'hC0, 1'b1, 1'b1, 1'b1, ST_UNSUP},     // tag
    '{8'hF7, 1'b1, 1'b1, 1'b1, ST_UNSUP},     // undefined
    '{8'hF6, 1'b1, 1'b0, 1'b0, ST_PENDING},
    '{8'h00, 1'b0, 1'b0, 1'b0, ST_PENDING},   // end marker without last
    '{8'h01, 1'b1, 1'b1, 1'b1, ST_TRAILING},  // byte after the value
    '{8'h62, 1'b1, 1'b0, 1'b0, ST_PENDING},
    '{8'hFF, 1'b1, 1'b1, 1'b1, ST_TRUNC},     // truncation beats bad utf-8
    '{8'h61, 1'b1, 1'b0, 1'b0, ST_PENDING},
    '{8'hFF, 1'b1, 1'b1, 1'b1, ST_UTF8},
    '{8'hFA, 1'b1, 1'b0, 1'b0, ST_PENDING},
    '{8'h7F, 1'b1, 1'b0, 1'b0, ST_PENDING},
    '{8'h80, 1'b1, 1'b0, 1'b0, ST_PENDING},
    '{8'h00, 1'b1, 1'b0, 1'b0, ST_PENDING},
    '{8'h00, 1'b1, 1'b1, 1'b1, ST_RANGE},     // float32 infinity
    '{8'h82, 1'b1, 1'b0, 1'b0, ST_PENDING},
    '{8'hA0, 1'b1, 1'b0, 1'b0, ST_PENDING},
    '{8'h80, 1'b1, 1'b1, 1'b1, ST_VALID},
    '{8'hE0, 1'b1, 1'b1, 1'b1, ST_UNSUP}
  };

  initial begin
    logic [7:0] msg[$];
    in_item_t it;
    out_item_t got;
    lim_nest = 5'd8; lim_bstr = 32'd65535; lim_text = 32'd65535; lim_items = 32'd255;
    clear_msg();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows: typed-in verdicts where marked, all checked by the predictor
    foreach (dir_tab[i]) begin
      it.data_byte = dir_tab[i].b;
      it.has_byte = dir_tab[i].has;
      it.last = dir_tab[i].lst;
      got = predict_status(it);
      if (dir_tab[i].chk && got.status != dir_tab[i].want)
        report($sformatf("table row %0d", i), got, '{dir_tab[i].want, 1'b1});
    end
    clear_msg();
    foreach (dir_tab[i]) push_byte(dir_tab[i].b, dir_tab[i].has, dir_tab[i].lst, 2);

    // random phases across limit settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: begin
          write_reg(REG_MAX_NESTING, 32'd0); write_reg(REG_MAX_BSTR, 32'd0);
          write_reg(REG_MAX_TEXT, 32'd0); write_reg(REG_MAX_ITEMS, 32'd0);
        end
        1: begin
          write_reg(REG_MAX_NESTING, 32'd16); write_reg(REG_MAX_BSTR, 32'hFFFF_FFFF);
          write_reg(REG_MAX_TEXT, 32'hFFFF_FFFF); write_reg(REG_MAX_ITEMS, 32'hFFFF_FFFF);
        end
        2: begin
          write_reg(REG_MAX_NESTING, 32'd2); write_reg(REG_MAX_BSTR, 32'd10);
          write_reg(REG_MAX_TEXT, 32'd12); write_reg(REG_MAX_ITEMS, 32'd2);
        end
        3: begin
          write_reg(REG_MAX_NESTING, 32'd31); write_reg(REG_MAX_ITEMS, 32'd3);
        end
        default: begin
          write_reg(REG_MAX_NESTING, 32'($urandom_range(1, 16)));
          write_reg(REG_MAX_BSTR, 32'($urandom_range(0, 40)));
          write_reg(REG_MAX_TEXT, 32'($urandom_range(0, 40)));
          write_reg(REG_MAX_ITEMS, 32'($urandom_range(0, 4)));
        end
      endcase
      if (ph == 3) begin
        // long receiver hold-off while bytes keep coming
        long_hold = 1'b1;
        for (int i = 0; i < 20; i++) push_byte(8'($urandom), 1'b1, i == 19, 0);
      end
      while (n_sent < 130 * (ph + 1) + 25) begin
        msg.delete();
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 6)) msg.push_back(8'($urandom));
          push_msg(msg, $urandom_range(0, 1) ? 0 : 12);
        end else begin
          gen_value(msg, 0);
          case ($urandom_range(0, 9))
            0: if (msg.size() > 1) msg.pop_back();          // cut short
            1: msg.push_back(8'($urandom));                 // trailing byte
            2: msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom);
            default: ;
          endcase
          if ($urandom_range(0, 7) == 0) begin
            for (int i = 0; i < msg.size(); i++) push_byte(msg[i], 1'b1, 1'b0, 3);
            push_byte(8'($urandom), 1'b0, 1'b1, 3);          // end marker alone
          end else begin
            if ($urandom_range(0, 9) == 0) push_byte(8'($urandom), 1'b0, 1'b0, 3);
            push_msg(msg, $urandom_range(0, 2) == 0 ? 0 : 12);
          end
        end
      end
    end

    stim_done = 1'b1;
    drain();
    $display("ran %0d byte transactions in %0d messages, %0d results checked", n_sent, n_msgs,
             n_results);
    $display("limits covered at zero, maximum and small values; nesting, strings, floats");
    if (errors == 0 && status_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, status_q.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
